/* design/lcdn_pkg.sv */
`timescale 1ns / 1ps

package lcdn_pkg;

    localparam int WAIT_W   = 20;
    localparam int COLS_W   = 6;
    localparam int CFG_IDX_W = 2;
    localparam int STEP_W   = 4;

    // request codes
    typedef enum logic [2:0] {
        CMD_INIT       = 3'd0,
        CMD_WRITE_CMD  = 3'd1,
        CMD_WRITE_DATA = 3'd2,
        CMD_SET_CURSOR = 3'd3,
        CMD_CLEAR      = 3'd4
    } lcdn_cmd_t;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_UP_WAIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMMAND_WAIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DATA_WAIT     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS       = 2'd3;

    localparam logic [WAIT_W-1:0] POWER_UP_WAIT_RST = 20'd100000;
    localparam logic [WAIT_W-1:0] COMMAND_WAIT_RST  = 20'd5000;
    localparam logic [WAIT_W-1:0] DATA_WAIT_RST     = 20'd50;
    localparam logic [COLS_W-1:0] COLUMNS_RST       = 6'd20;

    localparam logic [7:0] SET_DDRAM_ADDR = 8'h80;
    localparam logic [7:0] CLEAR_DISPLAY  = 8'h01;
    localparam logic [3:0] NIBBLE_WAKE    = 4'h3;
    localparam logic [3:0] NIBBLE_4BIT    = 4'h2;

    // init sequence step numbers
    localparam logic [STEP_W-1:0] STEP_POWER_UP  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_4BIT      = 4'd4;
    localparam logic [STEP_W-1:0] STEP_INIT_BYTE = 4'd5;
    localparam logic [STEP_W-1:0] STEP_INIT_LAST = 4'd14;

    // one queued job for the back end
    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic [7:0] byte_val;
    } lcdn_desc_t;

    typedef struct packed {
        logic empty;
        logic full;
    } lcdn_qstat_t;

    function automatic logic [7:0] row_base(input logic [1:0] r);
        logic [7:0] b;
        case (r)
            2'd0:    b = 8'h00;
            2'd1:    b = 8'h40;
            2'd2:    b = 8'h14;
            default: b = 8'h54;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] init_cmd(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h28;
            3'd1:    c = 8'h08;
            3'd2:    c = 8'h01;
            3'd3:    c = 8'h06;
            default: c = 8'h0C;
        endcase
        return c;
    endfunction

endpackage

/* design/char_lcd_nibble_interface.sv */
`timescale 1ns / 1ps

// Character LCD controller for the 4-bit bus. Each request beat (init, write
// command byte, write data byte, set cursor, clear) expands into bus events,
// one output beat per event: register select, the nibble on the data lines,
// whether enable is pulsed, and the wait in microseconds to hold off before
// the next event, with last marking the final event of a request. Init gives
// fifteen beats, every other request two; a set cursor with column at or past
// display_columns and unknown codes give none. Output beats leave at one per
// cycle while out_ready is high, so a request occupies the back-end
// sequencer only while its beats leave, and consecutive requests follow with
// no gap. The front end classifies a request in the cycle it is taken and
// drops it into a QUEUE_DEPTH-entry queue, so in_ready stays high until that
// queue fills, even while the output register waits on out_ready. Requests
// pass the queue, then the output register. Configuration is written through
// cfg_write / cfg_index / cfg_data and must only change while idle.
module char_lcd_nibble_interface #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration writes
    input  logic                          cfg_write,
    input  logic [lcdn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lcdn_pkg::WAIT_W-1:0]   cfg_data,
    // request channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    command,
    input  logic [7:0]                    byte_value,
    input  logic [7:0]                    column,
    input  logic [1:0]                    row,
    // bus event channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          register_select,
    output logic [3:0]                    bus_nibble,
    output logic                          strobe_res,
    output logic [lcdn_pkg::WAIT_W-1:0]   wait_after_us,
    output logic                          last
);
    import lcdn_pkg::*;

    // configuration registers
    logic [WAIT_W-1:0] power_up_wait_reg;
    logic [WAIT_W-1:0] command_wait_reg;
    logic [WAIT_W-1:0] data_wait_reg;
    logic [COLS_W-1:0] columns_reg;

    lcdn_desc_t  push_desc, head_desc;
    lcdn_qstat_t q_stat;
    logic        push, pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_up_wait_reg <= POWER_UP_WAIT_RST;
            command_wait_reg  <= COMMAND_WAIT_RST;
            data_wait_reg     <= DATA_WAIT_RST;
            columns_reg       <= COLUMNS_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_POWER_UP_WAIT: power_up_wait_reg <= cfg_data;
                CFG_COMMAND_WAIT:  command_wait_reg  <= cfg_data;
                CFG_DATA_WAIT:     data_wait_reg     <= cfg_data;
                CFG_COLUMNS:       columns_reg       <= cfg_data[COLS_W-1:0];
                default:           ;
            endcase
        end
    end

    // front end: take a request, resolve its byte and kind
    lcdn_front u_front (
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .byte_value      (byte_value),
        .column          (column),
        .row             (row),
        .display_columns (columns_reg),
        .q_stat          (q_stat),
        .push            (push),
        .desc            (push_desc)
    );

    // decoupling queue between classification and sequencing
    lcdn_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head_desc (head_desc),
        .q_stat    (q_stat)
    );

    // back end: step through the bus events of each job
    lcdn_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head_desc       (head_desc),
        .q_stat          (q_stat),
        .pop             (pop),
        .power_up_wait   (power_up_wait_reg),
        .command_wait    (command_wait_reg),
        .data_wait       (data_wait_reg),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .register_select (register_select),
        .bus_nibble      (bus_nibble),
        .strobe_res      (strobe_res),
        .wait_after_us   (wait_after_us),
        .last            (last)
    );

    // queue can never look empty and full at once
    a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.empty && q_stat.full))
        else $error("queue flags inconsistent");

    // only the power-up event comes without an enable pulse
    a_wait_only_event: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !strobe_res |-> !register_select && bus_nibble == 4'h0 && !last)
        else $error("bad wait-only event");

    // a data-register beat waits either zero or the data wait
    a_data_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && register_select |-> wait_after_us == '0 || wait_after_us == data_wait_reg)
        else $error("data beat with wrong wait");

endmodule

/* design/lcdn_front.sv */
`timescale 1ns / 1ps

module lcdn_front (
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [2:0]                 command,
    input  logic [7:0]                 byte_value,
    input  logic [7:0]                 column,
    input  logic [1:0]                 row,
    input  logic [lcdn_pkg::COLS_W-1:0] display_columns,
    input  lcdn_pkg::lcdn_qstat_t      q_stat,
    output logic                       push,
    output lcdn_pkg::lcdn_desc_t       desc
);
    import lcdn_pkg::*;

    logic has_events;

    always_comb
    begin
        has_events    = 1'b1;
        desc.is_init  = 1'b0;
        desc.rs       = 1'b0;
        desc.byte_val = byte_value;
        case (lcdn_cmd_t'(command))
            CMD_INIT:
            begin
                desc.is_init = 1'b1;
            end
            CMD_WRITE_CMD:
            begin
                desc.rs = 1'b0;
            end
            CMD_WRITE_DATA:
            begin
                desc.rs = 1'b1;
            end
            CMD_SET_CURSOR:
            begin
                // address wraps modulo 256
                desc.byte_val = SET_DDRAM_ADDR + row_base(row) + column;
                has_events    = (column < {2'b00, display_columns});
            end
            CMD_CLEAR:
            begin
                desc.byte_val = CLEAR_DISPLAY;
            end
            default:
            begin
                has_events = 1'b0;
            end
        endcase
    end

    // requests without events are taken and dropped
    assign in_ready = !q_stat.full;
    assign push     = in_valid && in_ready && has_events;

endmodule

/* design/lcdn_queue.sv */
`timescale 1ns / 1ps

module lcdn_queue #(
    parameter int DEPTH = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  lcdn_pkg::lcdn_desc_t  push_desc,
    input  logic                  pop,
    output lcdn_pkg::lcdn_desc_t  head_desc,
    output lcdn_pkg::lcdn_qstat_t q_stat
);
    import lcdn_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    lcdn_desc_t       entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == FULL_CNT);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head_desc    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

/* design/lcdn_back.sv */
`timescale 1ns / 1ps

module lcdn_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lcdn_pkg::lcdn_desc_t        head_desc,
    input  lcdn_pkg::lcdn_qstat_t       q_stat,
    output logic                        pop,
    input  logic [lcdn_pkg::WAIT_W-1:0] power_up_wait,
    input  logic [lcdn_pkg::WAIT_W-1:0] command_wait,
    input  logic [lcdn_pkg::WAIT_W-1:0] data_wait,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        register_select,
    output logic [3:0]                  bus_nibble,
    output logic                        strobe_res,
    output logic [lcdn_pkg::WAIT_W-1:0] wait_after_us,
    output logic                        last
);
    import lcdn_pkg::*;

    logic                busy_reg;
    logic [STEP_W-1:0]   step_reg;
    lcdn_desc_t          desc_reg;
    logic                out_valid_reg;
    logic                rs_reg, strobe_reg, last_reg;
    logic [3:0]          nibble_reg;
    logic [WAIT_W-1:0]   wait_reg;

    logic                advance, emit;
    lcdn_desc_t          cur;
    logic [STEP_W-1:0]   cur_step;
    logic [STEP_W-1:0]   k;
    logic [7:0]          cur_byte;
    logic [WAIT_W-1:0]   byte_wait;
    logic                ev_rs, ev_strobe, ev_last;
    logic [3:0]          ev_nibble;
    logic [WAIT_W-1:0]   ev_wait;

    assign advance  = !out_valid_reg || out_ready;
    assign pop      = advance && !busy_reg && !q_stat.empty;
    assign emit     = advance && (busy_reg || !q_stat.empty);
    assign cur      = busy_reg ? desc_reg : head_desc;
    assign cur_step = busy_reg ? step_reg : '0;
    assign k        = cur_step - STEP_INIT_BYTE;

    always_comb
    begin
        ev_rs     = 1'b0;
        ev_strobe = 1'b1;
        ev_nibble = '0;
        ev_wait   = '0;
        ev_last   = 1'b0;
        cur_byte  = cur.byte_val;
        byte_wait = cur.rs ? data_wait : command_wait;
        if (cur.is_init)
        begin
            cur_byte  = init_cmd(k[3:1]);
            byte_wait = command_wait;
            if (cur_step == STEP_POWER_UP)
            begin
                ev_strobe = 1'b0;
                ev_wait   = power_up_wait;
            end
            else if (cur_step < STEP_4BIT)
            begin
                ev_nibble = NIBBLE_WAKE;
                ev_wait   = command_wait;
            end
            else if (cur_step == STEP_4BIT)
            begin
                ev_nibble = NIBBLE_4BIT;
                ev_wait   = command_wait;
            end
            else
            begin
                // even offset: high nibble, odd offset: low nibble with wait
                ev_nibble = k[0] ? cur_byte[3:0] : cur_byte[7:4];
                ev_wait   = k[0] ? byte_wait : '0;
                ev_last   = (cur_step == STEP_INIT_LAST);
            end
        end
        else
        begin
            ev_rs     = cur.rs;
            ev_nibble = cur_step[0] ? cur_byte[3:0] : cur_byte[7:4];
            ev_wait   = cur_step[0] ? byte_wait : '0;
            ev_last   = cur_step[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
            if (emit)
            begin
                busy_reg <= !ev_last;
                step_reg <= cur_step + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            desc_reg <= head_desc;
        end
        if (emit)
        begin
            rs_reg     <= ev_rs;
            nibble_reg <= ev_nibble;
            strobe_reg <= ev_strobe;
            wait_reg   <= ev_wait;
            last_reg   <= ev_last;
        end
    end

    assign out_valid       = out_valid_reg;
    assign register_select = rs_reg;
    assign bus_nibble      = nibble_reg;
    assign strobe_res      = strobe_reg;
    assign wait_after_us   = wait_reg;
    assign last            = last_reg;

endmodule

/* dv/lcd_event_checker.sv */
`timescale 1ns / 1ps

module lcd_event_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [lcdn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lcdn_pkg::WAIT_W-1:0] cfg_data,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic [2:0]                  command,
    input  logic [7:0]                  byte_value,
    input  logic [7:0]                  column,
    input  logic [1:0]                  row,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic                        register_select,
    input  logic [3:0]                  bus_nibble,
    input  logic                        strobe_res,
    input  logic [lcdn_pkg::WAIT_W-1:0] wait_after_us,
    input  logic                        last,
    output int                          mismatches,
    output int                          beats_due
);

    import lcdn_pkg::*;

    // ddram line bases, line 0 in the low byte
    localparam logic [31:0] ROW_BASES  = 32'h54_14_40_00;
    // function set, display off, clear, entry mode, display on
    localparam logic [39:0] INIT_BYTES = 40'h28_08_01_06_0C;

    typedef struct packed {
        logic              rs;
        logic [3:0]        nibble;
        logic              strobe;
        logic [WAIT_W-1:0] wait_us;
        logic              fin;
    } bus_event_t;

    logic [WAIT_W-1:0] power_up_wait;
    logic [WAIT_W-1:0] command_wait;
    logic [WAIT_W-1:0] data_wait;
    logic [COLS_W-1:0] columns;
    bus_event_t        bus_events_due[$];
    bus_event_t        due;

    task automatic push_event(input logic rs, input logic [3:0] nib, input logic strobe,
                              input logic [WAIT_W-1:0] wait_us, input logic fin);
        bus_event_t ev;
        ev.rs      = rs;
        ev.nibble  = nib;
        ev.strobe  = strobe;
        ev.wait_us = wait_us;
        ev.fin     = fin;
        bus_events_due.push_back(ev);
    endtask

    // high nibble first with no wait, the wait follows the low nibble
    task automatic push_byte(input logic rs, input logic [7:0] b,
                             input logic [WAIT_W-1:0] wait_us, input logic fin);
        push_event(rs, b[7:4], 1'b1, '0, 1'b0);
        push_event(rs, b[3:0], 1'b1, wait_us, fin);
    endtask

    task automatic expand_request(input logic [2:0] cmd, input logic [7:0] b,
                                  input logic [7:0] col, input logic [1:0] r);
        logic [7:0] addr;
        int         i;
        addr = SET_DDRAM_ADDR + ROW_BASES[8*r +: 8] + col;
        case (cmd)
            CMD_INIT:
            begin
                push_event(1'b0, 4'h0, 1'b0, power_up_wait, 1'b0);
                for (i = 0; i < 3; i++)
                    push_event(1'b0, NIBBLE_WAKE, 1'b1, command_wait, 1'b0);
                push_event(1'b0, NIBBLE_4BIT, 1'b1, command_wait, 1'b0);
                for (i = 0; i < 5; i++)
                    push_byte(1'b0, INIT_BYTES[8*(4-i) +: 8], command_wait, i == 4);
            end
            CMD_WRITE_CMD:  push_byte(1'b0, b, command_wait, 1'b1);
            CMD_WRITE_DATA: push_byte(1'b1, b, data_wait, 1'b1);
            CMD_SET_CURSOR:
            begin
                if (col < {2'b00, columns})
                    push_byte(1'b0, addr, command_wait, 1'b1);
            end
            CMD_CLEAR:      push_byte(1'b0, CLEAR_DISPLAY, command_wait, 1'b1);
            default: ;
        endcase
    endtask

    task automatic check_field(input string field, input logic [WAIT_W-1:0] want,
                               input logic [WAIT_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            power_up_wait = POWER_UP_WAIT_RST;
            command_wait  = COMMAND_WAIT_RST;
            data_wait     = DATA_WAIT_RST;
            columns       = COLUMNS_RST;
            mismatches    = 0;
            bus_events_due.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_POWER_UP_WAIT: power_up_wait = cfg_data;
                    CFG_COMMAND_WAIT:  command_wait  = cfg_data;
                    CFG_DATA_WAIT:     data_wait     = cfg_data;
                    CFG_COLUMNS:       columns       = cfg_data[COLS_W-1:0];
                    default: ;
                endcase
            end
            // a beat leaving now can only belong to an earlier request
            if (out_valid && out_ready)
            begin
                if (bus_events_due.size() == 0)
                begin
                    $error("bus beat with nothing due: nibble %h last %b", bus_nibble, last);
                    mismatches++;
                end
                else
                begin
                    due = bus_events_due.pop_front();
                    check_field("register_select", WAIT_W'(due.rs),
                                WAIT_W'(register_select));
                    check_field("bus_nibble", WAIT_W'(due.nibble), WAIT_W'(bus_nibble));
                    check_field("strobe_res", WAIT_W'(due.strobe), WAIT_W'(strobe_res));
                    check_field("wait_after_us", due.wait_us, wait_after_us);
                    check_field("last", WAIT_W'(due.fin), WAIT_W'(last));
                end
            end
            if (in_valid && in_ready)
                expand_request(command, byte_value, column, row);
        end
        beats_due = bus_events_due.size();
    end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    import lcdn_pkg::*;

    // codes past clear; the block must swallow these without a beat
    localparam logic [2:0] CMD_RESERVED_FIRST = 3'd5;
    localparam logic [2:0] CMD_RESERVED_LAST  = 3'd7;
    // hold-off after the last due beat before touching the registers
    // or ending the run
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_ITEMS  = 65;
    localparam int PHASES       = 6;

    logic              clk;
    logic              rst_n;
    logic              cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [WAIT_W-1:0] cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [2:0]        command;
    logic [7:0]        byte_value;
    logic [7:0]        column;
    logic [1:0]        row;
    logic              out_valid;
    logic              out_ready;
    logic              register_select;
    logic [3:0]        bus_nibble;
    logic              strobe_res;
    logic [WAIT_W-1:0] wait_after_us;
    logic              last;

    int                mismatches;
    int                beats_due;
    // set for the closing phase: no gaps on either side
    logic              quiet;
    // mirror of display_columns, only used to steer cursor columns
    logic [COLS_W-1:0] cols_now;
    int                phase;

    char_lcd_nibble_interface dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .byte_value      (byte_value),
        .column          (column),
        .row             (row),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .register_select (register_select),
        .bus_nibble      (bus_nibble),
        .strobe_res      (strobe_res),
        .wait_after_us   (wait_after_us),
        .last            (last)
    );

    // watches both channels and the register port, predicts every bus beat
    lcd_event_checker events_chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .byte_value      (byte_value),
        .column          (column),
        .row             (row),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .register_select (register_select),
        .bus_nibble      (bus_nibble),
        .strobe_res      (strobe_res),
        .wait_after_us   (wait_after_us),
        .last            (last),
        .mismatches      (mismatches),
        .beats_due       (beats_due)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // worst case is far below this: ~410 requests, up to fifteen beats each,
    // every beat behind the longest sink stall, plus drains between phases
    initial
    begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    // sink side: random stall bursts, none in the closing phase
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // wait for every due beat, then a fixed margin
    task automatic wait_drained();
        while (beats_due != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // one request beat; called at a falling edge, returns at the falling edge
    // after acceptance with valid still high so the next beat can follow
    task automatic send_request(input logic [2:0] cmd, input logic [7:0] b,
                                input logic [7:0] col, input logic [1:0] r);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        in_valid   <= 1'b1;
        command    <= cmd;
        byte_value <= b;
        column     <= col;
        row        <= r;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // registers only change with the block idle, so drain first
    task automatic program_timing(input logic [WAIT_W-1:0] pu, input logic [WAIT_W-1:0] cw,
                                  input logic [WAIT_W-1:0] dw, input logic [WAIT_W-1:0] cols);
        in_valid <= 1'b0;
        wait_drained();
        cfg_write <= 1'b1;
        cfg_index <= CFG_POWER_UP_WAIT;
        cfg_data  <= pu;
        @(negedge clk);
        cfg_index <= CFG_COMMAND_WAIT;
        cfg_data  <= cw;
        @(negedge clk);
        cfg_index <= CFG_DATA_WAIT;
        cfg_data  <= dw;
        @(negedge clk);
        // upper data bits are dropped by the 6-bit column register
        cfg_index <= CFG_COLUMNS;
        cfg_data  <= cols;
        @(negedge clk);
        cfg_write <= 1'b0;
        cols_now = cols[COLS_W-1:0];
    endtask

    // mix weighted toward byte writes and cursor moves, a few inits,
    // some reserved codes and cursor columns off the end of the line
    task automatic random_request();
        int         pick;
        logic [2:0] cmd;
        logic [7:0] col;
        pick = $urandom_range(0, 99);
        col  = 8'($urandom_range(0, 255));
        if (pick < 4)
            cmd = CMD_INIT;
        else if (pick < 24)
            cmd = CMD_WRITE_CMD;
        else if (pick < 55)
            cmd = CMD_WRITE_DATA;
        else if (pick < 80)
        begin
            cmd = CMD_SET_CURSOR;
            if (cols_now != 0 && $urandom_range(0, 9) < 7)
                col = 8'($urandom_range(0, cols_now - 1));
        end
        else if (pick < 92)
            cmd = CMD_CLEAR;
        else
            cmd = 3'($urandom_range(CMD_RESERVED_FIRST, CMD_RESERVED_LAST));
        send_request(cmd, 8'($urandom_range(0, 255)), col, 2'($urandom_range(0, 3)));
    endtask

    initial
    begin
        rst_n      = 1'b0;
        quiet      = 1'b0;
        cfg_write  = 1'b0;
        cfg_index  = CFG_POWER_UP_WAIT;
        cfg_data   = '0;
        in_valid   = 1'b0;
        command    = CMD_INIT;
        byte_value = 8'h00;
        column     = 8'h00;
        row        = 2'd0;
        cols_now   = COLUMNS_RST;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed pass on the reset register values (20 columns)
        send_request(CMD_INIT, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 2'd2);
        send_request(CMD_WRITE_CMD, 8'h00, 8'h00, 2'd0);
        send_request(CMD_WRITE_CMD, 8'hFF, 8'hFF, 2'd3);
        send_request(CMD_WRITE_DATA, 8'h00, 8'h00, 2'd0);
        send_request(CMD_WRITE_DATA, 8'hFF, 8'hFF, 2'd3);
        send_request(CMD_WRITE_DATA, 8'h5A, 8'h11, 2'd1);
        send_request(CMD_WRITE_CMD, 8'hA5, 8'h00, 2'd0);
        send_request(CMD_CLEAR, 8'h3C, 8'h07, 2'd1);
        // each line base, first and last column
        send_request(CMD_SET_CURSOR, 8'h00, 8'd0, 2'd0);
        send_request(CMD_SET_CURSOR, 8'h00, 8'd19, 2'd1);
        send_request(CMD_SET_CURSOR, 8'h00, 8'd0, 2'd2);
        send_request(CMD_SET_CURSOR, 8'h00, 8'd19, 2'd3);
        // column equal to the width and far past it: no beats
        send_request(CMD_SET_CURSOR, 8'h00, 8'd20, 2'd1);
        send_request(CMD_SET_CURSOR, 8'h00, 8'd255, 2'd3);
        // reserved codes: no beats
        send_request(CMD_RESERVED_FIRST, 8'hFF, 8'h00, 2'd0);
        send_request(CMD_RESERVED_FIRST + 3'd1, 8'h00, 8'h00, 2'd0);
        send_request(CMD_RESERVED_LAST, 8'h00, 8'h00, 2'd0);
        // an init followed straight by a data write
        send_request(CMD_INIT, 8'h00, 8'h00, 2'd0);
        send_request(CMD_WRITE_DATA, 8'h81, 8'h00, 2'd0);

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                // all waits zero, single-column display
                0: program_timing('0, '0, '0, 20'd1);
                // every wait bit set, widest column register value; row 3
                // addresses past 0xFF wrap
                1: program_timing('1, '1, '1, 20'd63);
                2: program_timing(20'($urandom_range(0, 1000000)),
                                  20'($urandom_range(0, 1000000)),
                                  20'($urandom_range(0, 1000000)), 20'd40);
                // zero columns: every cursor move is dropped
                3: program_timing(20'($urandom_range(0, 1000000)),
                                  20'($urandom_range(0, 1000000)),
                                  20'($urandom_range(0, 1000000)), 20'd0);
                4: program_timing(20'($urandom_range(0, 1000000)),
                                  20'($urandom_range(0, 1000000)),
                                  20'($urandom_range(0, 1000000)),
                                  20'(($urandom & 20'hFFFC0) | $urandom_range(1, 40)));
                default:
                begin
                    quiet = 1'b1;
                    program_timing(20'($urandom_range(0, 1000000)),
                                   20'($urandom_range(0, 1000000)),
                                   20'($urandom_range(0, 1000000)),
                                   20'($urandom_range(1, 40)));
                end
            endcase
            // last valid column and first dropped one for this width
            send_request(CMD_SET_CURSOR, 8'($urandom_range(0, 255)),
                         {2'b00, cols_now} - 8'd1, 2'd3);
            send_request(CMD_SET_CURSOR, 8'($urandom_range(0, 255)), {2'b00, cols_now},
                         2'($urandom_range(0, 3)));
            repeat (PHASE_ITEMS) random_request();
        end

        in_valid <= 1'b0;
        wait_drained();
        if (mismatches == 0 && beats_due == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* filelist.f */
design/lcdn_pkg.sv
design/lcdn_front.sv
design/lcdn_queue.sv
design/lcdn_back.sv
design/char_lcd_nibble_interface.sv
dv/lcd_event_checker.sv
dv/tb_top.sv
